>>> hw/rtl/brb_pkg.sv
// brb_pkg: shared types, command codes and sizes for the byte ring buffer
// used by brb_status and byte_ring_buffer; no dependencies
`default_nettype none

package brb_pkg;

  // fixed field widths
  localparam int SIZE_W  = 11;
  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int CNT10_W = 10;

  // defaults for the top-level parameters
  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_MAX_BURST   = 64;

  // ring length after reset
  localparam int SIZE_RESET = 1000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd5;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_in;
    logic [SIZE_W-1:0] count;
  } brb_in_t;

  // result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic [SIZE_W-1:0]  moved_count;
    logic [CNT10_W-1:0] used_count;
    logic [CNT10_W-1:0] free_count;
    logic [SIZE_W-1:0]  contiguous_read;
    logic               last;
  } brb_out_t;

  // fill levels derived from the pointers
  typedef struct packed {
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] free;
    logic [SIZE_W-1:0] contig;
  } brb_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/brb_status.sv
// brb_status: registered used, free and contiguous byte counts from the pointers
// depends on brb_pkg
`default_nettype none

module brb_status
  import brb_pkg::*;
#(
  parameter int PTR_W = 10
) (
  input  wire logic              clk,
  input  wire logic [SIZE_W-1:0] size_in,
  input  wire logic [PTR_W-1:0]  rd_ptr,
  input  wire logic [PTR_W-1:0]  wr_ptr,
  output brb_stat_t              stat
);

  localparam int CW = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

  logic [CW-1:0] rp_e, wp_e, sz_e;
  logic [CW-1:0] used_w, free_w, contig_w;
  logic          wrapped;
  brb_stat_t     stat_r, stat_nxt;

  // levels for either pointer order, chosen by comparing the pointers
  always_comb begin
    rp_e     = CW'(rd_ptr);
    wp_e     = CW'(wr_ptr);
    sz_e     = CW'(size_in);
    wrapped  = wp_e < rp_e;
    if (wrapped) begin
      used_w   = sz_e - rp_e + wp_e;
      free_w   = rp_e - wp_e - CW'(1);
      contig_w = sz_e - rp_e;
    end else begin
      used_w   = wp_e - rp_e;
      free_w   = sz_e - CW'(1) - (wp_e - rp_e);
      contig_w = wp_e - rp_e;
    end
    stat_nxt.used   = used_w[SIZE_W-1:0];
    stat_nxt.free   = free_w[SIZE_W-1:0];
    stat_nxt.contig = contig_w[SIZE_W-1:0];
  end

  // level register
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
  end

  assign stat = stat_r;

endmodule

`default_nettype wire

>>> hw/rtl/byte_ring_buffer.sv
// byte_ring_buffer: byte ring with one slot kept empty, one-write one-read byte store
// depends on brb_pkg and brb_status
//
//   channel | ports                     | handshake
//   --------+---------------------------+-------------------------------------
//   input   | start, busy, in_beat      | taken when start is high, busy low
//   result  | out_strobe, out_beat      | one cycle per beat, cannot be held
//   config  | cfg_wr_en, cfg_wr_data    | written when cfg_wr_en is high
//
// put, remove, advance write and status step through decide, pointer update, level
// settle and result load before the next accept; get and peek that return bytes
// replace result load by a burst, one byte a cycle from the store read port.
// after reset a clearing pass writes zero to every entry with busy high;
// config writes are taken during it. the result side has no stall; results go
// out on a fixed schedule.
`default_nettype none

module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_BURST   = DEF_MAX_BURST
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire brb_in_t           in_beat,
  output logic                   out_strobe,
  output brb_out_t               out_beat,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int CW    = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;
  localparam int BW    = $clog2(MAX_BURST + 1);
  localparam int SIZE_INIT = (SIZE_RESET > STORE_DEPTH) ? STORE_DEPTH : SIZE_RESET;

  // sequencer states
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_BURST = 3'd6;
  localparam logic [2:0] ST_DRAIN = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [PTR_W-1:0]  rp_r, wp_r;
  logic [PTR_W-1:0]  clr_r;
  brb_in_t           cmd_r;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic              rp_mv_r, wp_mv_r;
  logic [PTR_W-1:0]  base_r;
  logic [BW-1:0]     bcnt_r;
  logic              rd_pend_r, rd_last_r;
  logic              out_strobe_r;
  brb_out_t          out_r;
  brb_stat_t         stat;

  // store and its ports
  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic [PTR_W-1:0]  rd_addr;
  logic [CW-1:0]     rd_sum;

  logic [SIZE_W-1:0] size_cfg;
  logic [SIZE_W-1:0] burst_min;
  logic [CW-1:0]     rp_sum, wp_sum;
  logic [PTR_W-1:0]  rp_nxt, wp_nxt;
  logic              burst_done;
  logic              is_burst_cmd;

  brb_status #(.PTR_W(PTR_W)) u_status (
    .clk     (clk),
    .size_in (size_r),
    .rd_ptr  (rp_r),
    .wr_ptr  (wp_r),
    .stat    (stat)
  );

  assign busy         = (state_r != ST_IDLE);
  assign is_burst_cmd = (cmd_r.command inside {CMD_GET, CMD_PEEK});

  // clamp of a written ring length
  always_comb begin
    if (cfg_wr_data < SIZE_W'(2)) begin
      size_cfg = SIZE_W'(2);
    end else if (32'(cfg_wr_data) > STORE_DEPTH) begin
      size_cfg = SIZE_W'(STORE_DEPTH);
    end else begin
      size_cfg = cfg_wr_data;
    end
  end

  // bytes moved by the held command, from the settled levels
  always_comb begin
    burst_min = (cmd_r.count < stat.contig) ? cmd_r.count : stat.contig;
    case (cmd_r.command)
      CMD_PUT: begin
        n_nxt = (stat.free != '0) ? SIZE_W'(1) : '0;
      end
      CMD_GET, CMD_PEEK: begin
        n_nxt = (burst_min > SIZE_W'(MAX_BURST)) ? SIZE_W'(MAX_BURST) : burst_min;
      end
      CMD_REMOVE: begin
        n_nxt = (cmd_r.count <= stat.used) ? cmd_r.count : '0;
      end
      CMD_ADVANCE: begin
        n_nxt = (cmd_r.count <= stat.free) ? cmd_r.count : '0;
      end
      default: begin
        n_nxt = '0;
      end
    endcase
  end

  // pointer advance with one wrap correction
  always_comb begin
    rp_sum = CW'(rp_r) + (rp_mv_r ? CW'(n_r) : '0);
    wp_sum = CW'(wp_r) + (wp_mv_r ? CW'(n_r) : '0);
    if (rp_sum >= CW'(size_r)) begin
      rp_sum = rp_sum - CW'(size_r);
    end
    if (wp_sum >= CW'(size_r)) begin
      wp_sum = wp_sum - CW'(size_r);
    end
    rp_nxt = rp_sum[PTR_W-1:0];
    wp_nxt = wp_sum[PTR_W-1:0];
  end

  // burst read address, never past the ring end
  assign rd_sum     = CW'(base_r) + CW'(bcnt_r);
  assign rd_addr    = rd_sum[PTR_W-1:0];
  assign burst_done = ((SIZE_W'(bcnt_r) + SIZE_W'(1)) == n_r);

  // store write port: clearing pass or put
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wp_r;
    mem_wd = cmd_r.data_in;
    if (state_r == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (state_r == ST_UPD && cmd_r.command == CMD_PUT && n_r != '0) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_r == PTR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_WAIT;
      ST_WAIT: begin
        state_nxt = (is_burst_cmd && n_r != '0) ? ST_BURST : ST_FIN;
      end
      ST_FIN:   state_nxt = ST_IDLE;
      ST_BURST: begin
        if (burst_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      size_r       <= SIZE_W'(SIZE_INIT);
      rp_r         <= '0;
      wp_r         <= '0;
      out_strobe_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_last_r    <= 1'b0;
      bcnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + PTR_W'(1);
      end
      // pointers: config write empties the ring
      if (cfg_wr_en) begin
        size_r <= size_cfg;
        rp_r   <= '0;
        wp_r   <= '0;
      end else if (state_r == ST_UPD) begin
        rp_r <= rp_nxt;
        wp_r <= wp_nxt;
      end
      // burst counter and read tracking
      if (state_r == ST_BURST) begin
        bcnt_r <= bcnt_r + BW'(1);
      end else begin
        bcnt_r <= '0;
      end
      rd_pend_r    <= (state_r == ST_BURST);
      rd_last_r    <= (state_r == ST_BURST) && burst_done;
      out_strobe_r <= (state_r == ST_FIN) || rd_pend_r;
    end
  end

  // command hold and decision
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      cmd_r <= in_beat;
    end
    if (state_r == ST_CALC) begin
      n_r     <= n_nxt;
      base_r  <= rp_r;
      rp_mv_r <= (cmd_r.command inside {CMD_GET, CMD_REMOVE});
      wp_mv_r <= (cmd_r.command inside {CMD_PUT, CMD_ADVANCE});
    end
  end

  // result beat register, levels after the command
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN || rd_pend_r) begin
      out_r.data_out        <= rd_pend_r ? mem_q : '0;
      out_r.moved_count     <= n_r;
      out_r.used_count      <= stat.used[CNT10_W-1:0];
      out_r.free_count      <= stat.free[CNT10_W-1:0];
      out_r.contiguous_read <= stat.contig;
      out_r.last            <= rd_pend_r ? rd_last_r : 1'b1;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_r;

  // the final beat of a command goes out while the block is ready again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.last |-> !busy)
    else $error("final result beat while busy");

  // pointers stay inside the active ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(rp_r) < CW'(size_r)) && (CW'(wp_r) < CW'(size_r)))
    else $error("pointer beyond ring length");

  // no result during the clearing pass
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |-> !out_strobe_r && !rd_pend_r)
    else $error("result beat during clearing pass");

  // a burst never runs past its byte count
  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BURST |-> (SIZE_W'(bcnt_r) < n_r))
    else $error("burst read beyond byte count");

endmodule

`default_nettype wire

>>> sim/byte_ring_buffer_tb.sv
// byte_ring_buffer_tb: self-checking bench for the byte ring buffer, with an in-bench
// predictor of ring pointers and store, driven through the start/busy command port
// depends on brb_pkg and byte_ring_buffer
`timescale 1ns / 1ps

module byte_ring_buffer_tb;
  import brb_pkg::*;

  // spare command codes, decoded as status by the block
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 48;

  // ring predictor and store of expected result beats
  class ring_scoreboard;
    logic [BYTE_W-1:0] store [DEF_STORE_DEPTH];
    int unsigned       rd;
    int unsigned       wr;
    int unsigned       len;
    brb_out_t          pending [$];
    int unsigned       errors;
    int unsigned       beats;
    int unsigned       commands;

    function new();
      foreach (store[i]) store[i] = '0;
      rd       = 0;
      wr       = 0;
      len      = SIZE_RESET;
      errors   = 0;
      beats    = 0;
      commands = 0;
    endfunction

    function int unsigned held();
      if (wr >= rd) return wr - rd;
      return len - rd + wr;
    endfunction

    function int unsigned room();
      return len - 1 - held();
    endfunction

    function int unsigned contig();
      if (wr < rd) return len - rd;
      return held();
    endfunction

    function int unsigned wrap(int unsigned p, int unsigned n);
      int unsigned s;
      s = p + n;
      while (s >= len) s -= len;
      return s;
    endfunction

    // levels are taken after the command has updated the pointers
    function brb_out_t make_beat(logic [BYTE_W-1:0] d, int unsigned moved, bit fin);
      brb_out_t r;
      r.data_out        = d;
      r.moved_count     = SIZE_W'(moved);
      r.used_count      = CNT10_W'(held());
      r.free_count      = CNT10_W'(room());
      r.contiguous_read = SIZE_W'(contig());
      r.last            = fin;
      return r;
    endfunction

    // size write clamps into range and empties the ring, store kept
    function void note_size(logic [SIZE_W-1:0] v);
      if (v < 2) len = 2;
      else if (v > DEF_STORE_DEPTH) len = DEF_STORE_DEPTH;
      else len = v;
      rd = 0;
      wr = 0;
    endfunction

    function void note_command(brb_in_t b);
      logic [BYTE_W-1:0] burst [$];
      int unsigned       n;
      n = 0;
      commands++;
      case (b.command)
        CMD_PUT: begin
          if (room() >= 1) begin
            store[wr] = b.data_in;
            wr = wrap(wr, 1);
            n = 1;
          end
          pending.push_back(make_beat('0, n, 1'b1));
        end
        CMD_GET, CMD_PEEK: begin
          // limited by fill, by the ring end when wrapped, then by the burst cap
          n = b.count;
          if (n > held()) n = held();
          if (wr < rd && n > len - rd) n = len - rd;
          if (n > DEF_MAX_BURST) n = DEF_MAX_BURST;
          for (int i = 0; i < n; i++)
            burst.push_back((rd + i < DEF_STORE_DEPTH) ? store[rd + i] : '0);
          if (b.command == CMD_GET) rd = wrap(rd, n);
          if (n == 0) pending.push_back(make_beat('0, 0, 1'b1));
          foreach (burst[i]) pending.push_back(make_beat(burst[i], n, i == n - 1));
        end
        CMD_REMOVE: begin
          if (b.count <= held()) begin
            rd = wrap(rd, b.count);
            n = b.count;
          end
          pending.push_back(make_beat('0, n, 1'b1));
        end
        CMD_ADVANCE: begin
          if (b.count <= room()) begin
            wr = wrap(wr, b.count);
            n = b.count;
          end
          pending.push_back(make_beat('0, n, 1'b1));
        end
        default: pending.push_back(make_beat('0, 0, 1'b1));
      endcase
    endfunction

    function void field_ok(string name, logic [SIZE_W-1:0] want, logic [SIZE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(brb_out_t got);
      brb_out_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      beats++;
      field_ok("data_out", SIZE_W'(want.data_out), SIZE_W'(got.data_out));
      field_ok("moved_count", want.moved_count, got.moved_count);
      field_ok("used_count", SIZE_W'(want.used_count), SIZE_W'(got.used_count));
      field_ok("free_count", SIZE_W'(want.free_count), SIZE_W'(got.free_count));
      field_ok("contiguous_read", want.contiguous_read, got.contiguous_read);
      field_ok("last", SIZE_W'(want.last), SIZE_W'(got.last));
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  brb_in_t           in_beat     = '0;
  logic              out_strobe;
  brb_out_t          out_beat;
  logic              cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  ring_scoreboard    sb;
  int unsigned       cur_len     = SIZE_RESET;
  int                cycle_count = 0;

  byte_ring_buffer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_beat     (in_beat),
    .out_strobe  (out_strobe),
    .out_beat    (out_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("byte_ring_buffer: mismatch");
      $finish;
    end
  end

  // monitor: results checked before the command accepted on the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) sb.check_beat(out_beat);
      if (start === 1'b1 && busy === 1'b0) sb.note_command(in_beat);
    end
  end

  // one command beat, after an optional gap with junk on the bus
  task automatic issue(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] d,
                       logic [SIZE_W-1:0] n, int gap);
    brb_in_t b;
    if (gap > 0) begin
      b.command = CMD_W'($urandom);
      b.data_in = BYTE_W'($urandom);
      b.count   = SIZE_W'($urandom);
      start   <= 1'b0;
      in_beat <= b;
      repeat (gap) @(posedge clk);
    end
    b.command = cmd;
    b.data_in = d;
    b.count   = n;
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // hold off until every expected beat is back and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.note_size(v);
    cur_len = sb.len;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // sender idle with the given percentage, with idle-free stretches
  function automatic int draw_gap(int pct, int k);
    int g;
    g = 0;
    if ((k / 20) % 4 == 3) return 0;
    while (g < 30 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 42) return CMD_PUT;
    if (r < 58) return CMD_GET;
    if (r < 67) return CMD_PEEK;
    if (r < 76) return CMD_REMOVE;
    if (r < 86) return CMD_ADVANCE;
    if (r < 94) return CMD_STATUS;
    if (r < 97) return CMD_SPARE6;
    return CMD_SPARE7;
  endfunction

  // mostly small counts, some up to the ring length, a few over the whole field
  function automatic logic [SIZE_W-1:0] pick_count();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r <= 5) return SIZE_W'($urandom_range(1, 8));
    if (r <= 7) return SIZE_W'($urandom_range(0, 70));
    if (r == 8) return SIZE_W'($urandom_range(0, cur_len));
    return SIZE_W'($urandom_range(0, 2047));
  endfunction

  // random part: runs of puts drained by a get or peek, mixed with single commands
  task automatic run_phase(int n_items, int pct);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 3) begin
        run = $urandom_range(1, 12);
        for (int k = 0; k < run; k++) begin
          issue(CMD_PUT, BYTE_W'($urandom), SIZE_W'($urandom), draw_gap(pct, sent));
          sent++;
        end
        issue($urandom_range(1) ? CMD_GET : CMD_PEEK, BYTE_W'($urandom),
              SIZE_W'(run), draw_gap(pct, sent));
        sent++;
      end else begin
        issue(pick_command(), BYTE_W'($urandom), pick_count(), draw_gap(pct, sent));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [PHASES];
    int                idle_pct [PHASES];
    sb = new();
    sizes    = '{11'd0, 11'd16, 11'd2047, 11'd7, 11'd2, 11'd1024, 11'd0, 11'd1000};
    sizes[6] = SIZE_W'($urandom_range(0, 2047));
    idle_pct = '{0, 82, 23, 0, 82, 23, 0, 82};

    // reset, then wait out the clearing pass through busy
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, edge bytes, burst cap, wrap, full ring, spare codes
    issue(CMD_STATUS, 8'h00, 11'd0, 0);
    issue(CMD_GET, 8'hFF, 11'd0, 0);
    issue(CMD_PEEK, 8'h00, 11'd5, 0);
    issue(CMD_REMOVE, 8'h00, 11'd1, 0);
    issue(CMD_ADVANCE, 8'h00, 11'd2047, 0);
    issue(CMD_PUT, 8'h00, 11'd0, 0);
    issue(CMD_PUT, 8'hFF, 11'd2047, 0);
    issue(CMD_PUT, 8'hA5, 11'd0, 0);
    issue(CMD_PUT, 8'h5A, 11'd0, 0);
    issue(CMD_PEEK, 8'h00, 11'd2, 0);
    issue(CMD_GET, 8'h00, 11'd1, 0);
    issue(CMD_GET, 8'h00, 11'd2047, 0);
    issue(CMD_ADVANCE, 8'h00, 11'd200, 0);
    issue(CMD_PEEK, 8'h00, 11'd1024, 0);
    issue(CMD_GET, 8'h00, 11'd100, 0);
    issue(CMD_GET, 8'h00, 11'd2047, 0);
    issue(CMD_REMOVE, 8'h00, 11'd72, 0);
    issue(CMD_ADVANCE, 8'h00, 11'd995, 0);
    issue(CMD_PUT, 8'h3C, 11'd0, 0);
    issue(CMD_ADVANCE, 8'h00, 11'd3, 0);
    issue(CMD_PUT, 8'hC3, 11'd0, 0);
    issue(CMD_ADVANCE, 8'h00, 11'd1, 0);
    issue(CMD_REMOVE, 8'h00, 11'd2047, 0);
    issue(CMD_SPARE6, 8'h00, 11'd0, 0);
    issue(CMD_SPARE7, 8'hFF, 11'd2047, 0);
    issue(CMD_GET, 8'h00, 11'd1024, 0);

    // random phases, each on a fresh ring size written while idle
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_size(sizes[p]);
      run_phase(PHASE_ITEMS, idle_pct[p]);
    end

    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $error("%0d expected beats never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("%0d commands over %0d ring sizes, %0d result beats checked",
             sb.commands, PHASES + 1, sb.beats);
    if (sb.errors == 0) begin
      $display("byte_ring_buffer: match");
    end else begin
      $display("byte_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule

>>> byte_ring_buffer.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_status.sv
hw/rtl/byte_ring_buffer.sv
sim/byte_ring_buffer_tb.sv
